// ===== hw/rtl/vhp_pkg.sv =====
// ----------------------------------------------------------------------------
// vhp_pkg
// Shared types and constants for the VRRP advertisement header parser.
// ----------------------------------------------------------------------------
package vhp_pkg;

	localparam int unsigned HDR_LEN    = 8;
	localparam int unsigned AUTH_LEN   = 8;
	localparam int unsigned V4_SHIFT   = 2;   // 4-byte addresses
	localparam int unsigned V6_SHIFT   = 4;   // 16-byte addresses
	localparam int unsigned NEED_BITS  = 12;  // 255 * 16 fits in 12 bits
	localparam logic [3:0]  VER_AUTH   = 4'd3;
	localparam logic [3:0]  IVAL_MASK  = 4'h0f;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SHORT = 2'd1,
		ST_ADDR  = 2'd2,
		ST_AUTH  = 2'd3
	} status_t;

	// Packet record passed from the byte front end to the result back end
	typedef struct packed {
		logic [63:0] hdr;
		logic [63:0] auth;
		logic        ipv6;
		logic        short_pkt;
	} job_t;

	// Counter update issued by the back end for each result it builds
	typedef struct packed {
		logic        inc;
		logic [31:0] bytes;
	} cnt_upd_t;

endpackage

// ===== hw/rtl/vrrp_if.sv =====
// ----------------------------------------------------------------------------
// vrrp_if
// Valid/ready channels: packet bytes in, parsed advertisement results out.
// ----------------------------------------------------------------------------
interface vrrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;
	logic       over_ipv6;

	modport source (output valid, output byte_value, output last_byte, output over_ipv6,
		input ready);
	modport sink (input valid, input byte_value, input last_byte, input over_ipv6,
		output ready);
endinterface

interface vrrp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [3:0]  version;
	logic [3:0]  msg_type;
	logic [7:0]  router_id;
	logic [7:0]  priority_res;
	logic [7:0]  addr_count;
	logic [7:0]  auth_kind;
	logic [11:0] advert_interval;
	logic [15:0] checksum;
	logic [63:0] auth_data;

	modport source (output valid, output status, output version, output msg_type,
		output router_id, output priority_res, output addr_count, output auth_kind,
		output advert_interval, output checksum, output auth_data, input ready);
	modport sink (input valid, input status, input version, input msg_type,
		input router_id, input priority_res, input addr_count, input auth_kind,
		input advert_interval, input checksum, input auth_data, output ready);
endinterface

// ===== hw/rtl/vhp_front.sv =====
// ----------------------------------------------------------------------------
// vhp_front
// Byte front end: tracks position, gathers header and trailing bytes, and
// hands a packet record to the queue on the last byte.
// ----------------------------------------------------------------------------
module vhp_front #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	vrrp_byte_if.sink                byte_in,
	input  logic                     q_full,
	output logic                     push,
	output vhp_pkg::job_t            job,
	output logic [POSITION_BITS-1:0] job_len
);
	import vhp_pkg::*;

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_next;
	logic [63:0]              hdr_q;
	logic [63:0]              hdr_next;
	logic [63:0]              auth_q;
	logic [63:0]              auth_next;
	logic                     ipv6_q;
	logic                     ipv6_next;
	logic                     xfer;

	assign byte_in.ready = !q_full;
	assign xfer          = byte_in.valid && byte_in.ready;

	// saturate the position at all ones
	assign pos_next  = (pos_q == '1) ? pos_q : pos_q + POSITION_BITS'(1);
	assign ipv6_next = (pos_q == '0) ? byte_in.over_ipv6 : ipv6_q;
	assign auth_next = {auth_q[55:0], byte_in.byte_value};

	always_comb begin
		hdr_next = hdr_q;
		for (int i = 0; i < HDR_LEN; i++) begin
			if (pos_q == POSITION_BITS'(i)) begin
				hdr_next[8*(HDR_LEN-1-i) +: 8] = byte_in.byte_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (xfer) begin
			pos_q <= byte_in.last_byte ? '0 : pos_next;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			hdr_q  <= hdr_next;
			auth_q <= auth_next;
			ipv6_q <= ipv6_next;
		end
	end

	assign push          = xfer && byte_in.last_byte;
	assign job.hdr       = hdr_next;
	assign job.auth      = auth_next;
	assign job.ipv6      = ipv6_next;
	assign job.short_pkt = pos_next < POSITION_BITS'(HDR_LEN);
	assign job_len       = pos_next;

endmodule

// ===== hw/rtl/vhp_queue.sv =====
// ----------------------------------------------------------------------------
// vhp_queue
// Two-entry FIFO between the byte front end and the result back end.
// ----------------------------------------------------------------------------
module vhp_queue #(
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             rvalid,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign rvalid = (cnt_q != 2'd0);
	assign rdata  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/vhp_back.sv =====
// ----------------------------------------------------------------------------
// vhp_back
// Result back end: checks lengths, decodes the header and holds the result
// in an output register until it is taken.
// ----------------------------------------------------------------------------
module vhp_back #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  vhp_pkg::job_t            job,
	input  logic [POSITION_BITS-1:0] job_len,
	output logic                     pop,
	output vhp_pkg::cnt_upd_t        upd,
	vrrp_res_if.source               result_out
);
	import vhp_pkg::*;

	logic [3:0]               ver;
	logic [7:0]               count;
	logic [NEED_BITS-1:0]     need;
	logic [POSITION_BITS-1:0] rem;
	logic [POSITION_BITS-1:0] rem_auth;
	logic                     addr_over;
	logic                     auth_present;
	status_t                  status;
	logic                     valid_q;

	assign ver   = job.hdr[63:60];
	assign count = job.hdr[39:32];
	assign need  = job.ipv6 ? NEED_BITS'({count, 4'b0}) : NEED_BITS'({count, 2'b0});

	assign rem          = job_len - POSITION_BITS'(HDR_LEN);
	assign addr_over    = POSITION_BITS'(need) > rem;
	assign rem_auth     = rem - POSITION_BITS'(need);
	assign auth_present = (rem_auth != '0) && (ver < VER_AUTH);

	always_comb begin
		if (job.short_pkt) begin
			status = ST_SHORT;
		end else if (addr_over) begin
			status = ST_ADDR;
		end else if (auth_present && rem_auth != POSITION_BITS'(AUTH_LEN)) begin
			status = ST_AUTH;
		end else begin
			status = ST_OK;
		end
	end

	// take a new record whenever the output register is free or being drained
	assign pop = q_valid && (!valid_q || result_out.ready);

	assign upd.inc   = pop && (status == ST_OK);
	assign upd.bytes = 32'(rem_auth);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_out.status <= status;
			if (job.short_pkt) begin
				result_out.version         <= '0;
				result_out.msg_type        <= '0;
				result_out.router_id       <= '0;
				result_out.priority_res    <= '0;
				result_out.addr_count      <= '0;
				result_out.auth_kind       <= '0;
				result_out.advert_interval <= '0;
				result_out.checksum        <= '0;
				result_out.auth_data       <= '0;
			end else begin
				result_out.version      <= ver;
				result_out.msg_type     <= job.hdr[59:56];
				result_out.router_id    <= job.hdr[55:48];
				result_out.priority_res <= job.hdr[47:40];
				result_out.addr_count   <= count;
				result_out.checksum     <= job.hdr[15:0];
				if (ver < VER_AUTH) begin
					result_out.auth_kind       <= job.hdr[31:24];
					result_out.advert_interval <= {4'b0, job.hdr[23:16]};
				end else if (ver == VER_AUTH) begin
					result_out.auth_kind       <= '0;
					result_out.advert_interval <= {job.hdr[27:24] & IVAL_MASK,
						job.hdr[23:16]};
				end else begin
					result_out.auth_kind       <= '0;
					result_out.advert_interval <= '0;
				end
				result_out.auth_data <= (status == ST_OK && auth_present) ? job.auth : '0;
			end
		end
	end

	assign result_out.valid = valid_q;

endmodule

// ===== hw/rtl/vrrp_header_parser.sv =====
// ----------------------------------------------------------------------------
// vrrp_header_parser
// VRRP advertisement header parser: one byte per cycle in while the queue has
// room, one result per packet out, with accepted-packet and trailing-byte counters.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the queue is not full.
// After the last byte is transferred, its record is written into the queue and
// then into the back end output register, which raises the result valid.
// A two-entry queue lets the byte side run on while a result is stalled.
// Reset: position, queue and output valid cleared, counters zeroed; no sweep.
// ----------------------------------------------------------------------------
module vrrp_header_parser #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	vrrp_byte_if.sink   byte_in,
	vrrp_res_if.source  result_out
);
	import vhp_pkg::*;

	localparam int unsigned QW = $bits(job_t) + POSITION_BITS;

	logic                     push;
	logic                     pop;
	logic                     q_full;
	logic                     q_valid;
	job_t                     job_w;
	job_t                     job_r;
	logic [POSITION_BITS-1:0] len_w;
	logic [POSITION_BITS-1:0] len_r;
	cnt_upd_t                 upd;
	logic [31:0]              packets_q;
	logic [31:0]              bytes_q;

	vhp_front #(.POSITION_BITS(POSITION_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.q_full  (q_full),
		.push    (push),
		.job     (job_w),
		.job_len (len_w)
	);

	vhp_queue #(.WIDTH(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  ({len_w, job_w}),
		.full   (q_full),
		.pop    (pop),
		.rvalid (q_valid),
		.rdata  ({len_r, job_r})
	);

	vhp_back #(.POSITION_BITS(POSITION_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.job        (job_r),
		.job_len    (len_r),
		.pop        (pop),
		.upd        (upd),
		.result_out (result_out)
	);

	// count only packets that parsed clean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packets_q <= '0;
			bytes_q   <= '0;
		end else if (upd.inc) begin
			packets_q <= packets_q + 32'd1;
			bytes_q   <= bytes_q + upd.bytes;
		end
	end

	a_cnt_follows_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(packets_q != $past(packets_q)) |-> $past(upd.inc))
		else $error("packet counter moved without a clean result");

	a_bytes_with_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		(bytes_q != $past(bytes_q)) |-> (packets_q != $past(packets_q)))
		else $error("byte counter moved without a packet");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.status == ST_SHORT) |->
		(result_out.version == 4'd0 && result_out.checksum == 16'd0 &&
		result_out.auth_data == 64'd0))
		else $error("short packet result carries header data");

	a_auth_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.auth_data != 64'd0) |->
		(result_out.status == ST_OK && result_out.version < VER_AUTH))
		else $error("auth data given for a bad or v3 packet");

endmodule

// ===== tb/sv/vhp_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vhp_tb_pkg
// Scoreboard for the VRRP header parser: follows the byte stream, works out
// the advertisement result each packet should produce and checks the results
// that come out, field by field and in order.
// ----------------------------------------------------------------------------
package vhp_tb_pkg;

	import vhp_pkg::*;

	localparam int unsigned POS_BITS = 16;

	typedef struct packed {
		status_t     status;
		logic [3:0]  version;
		logic [3:0]  msg_type;
		logic [7:0]  router_id;
		logic [7:0]  priority_res;
		logic [7:0]  addr_count;
		logic [7:0]  auth_kind;
		logic [11:0] advert_interval;
		logic [15:0] checksum;
		logic [63:0] auth_data;
	} advert_t;

	class advert_board;
		logic [POS_BITS-1:0] pos;
		logic [63:0]         hdr_bytes;
		logic [63:0]         tail_bytes;
		logic                v6;
		advert_t             due_adverts[$];
		int unsigned         mismatches;

		function new();
			clear_packet();
			mismatches = 0;
		endfunction

		function void clear_packet();
			pos        = '0;
			hdr_bytes  = '0;
			tail_bytes = '0;
			v6         = 1'b0;
		endfunction

		function int unsigned pending();
			return due_adverts.size();
		endfunction

		// Advance the packet state by one transferred byte; queue a result on the last
		function void take_byte(logic [7:0] b, logic lst, logic v6_in);
			advert_t     a;
			logic [3:0]  ver;
			logic [7:0]  cnt;
			int unsigned len;
			int unsigned room;
			int unsigned span;

			if (pos == 0)
				v6 = v6_in;
			if (pos < HDR_LEN)
				hdr_bytes[63 - 8 * pos -: 8] = b;
			tail_bytes = {tail_bytes[55:0], b};
			if (~&pos)
				pos++;
			if (!lst)
				return;

			a   = '0;
			len = pos;
			if (len < HDR_LEN) begin
				a.status = ST_SHORT;
			end else begin
				ver            = hdr_bytes[63:60];
				cnt            = hdr_bytes[39:32];
				a.version      = ver;
				a.msg_type     = hdr_bytes[59:56];
				a.router_id    = hdr_bytes[55:48];
				a.priority_res = hdr_bytes[47:40];
				a.addr_count   = cnt;
				a.checksum     = hdr_bytes[15:0];
				if (ver < VER_AUTH) begin
					a.auth_kind       = hdr_bytes[31:24];
					a.advert_interval = {4'h0, hdr_bytes[23:16]};
				end else if (ver == VER_AUTH) begin
					a.advert_interval = {hdr_bytes[27:24], hdr_bytes[23:16]};
				end
				span = cnt * (v6 ? 16 : 4);
				room = len - HDR_LEN;
				if (span > room) begin
					a.status = ST_ADDR;
				end else begin
					room -= span;
					// trailing bytes only matter below version 3
					if (room > 0 && ver < VER_AUTH) begin
						if (room != AUTH_LEN)
							a.status = ST_AUTH;
						else
							a.auth_data = tail_bytes;
					end
				end
			end
			due_adverts.push_back(a);
			clear_packet();
		endfunction

		function void match_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(advert_t got);
			advert_t want;

			if (due_adverts.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, got.status);
				mismatches++;
				return;
			end
			want = due_adverts.pop_front();
			match_field("status", want.status, got.status);
			match_field("version", want.version, got.version);
			match_field("msg_type", want.msg_type, got.msg_type);
			match_field("router_id", want.router_id, got.router_id);
			match_field("priority_res", want.priority_res, got.priority_res);
			match_field("addr_count", want.addr_count, got.addr_count);
			match_field("auth_kind", want.auth_kind, got.auth_kind);
			match_field("advert_interval", want.advert_interval, got.advert_interval);
			match_field("checksum", want.checksum, got.checksum);
			match_field("auth_data", want.auth_data, got.auth_data);
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives VRRP packets byte by byte into the header parser - directed corner
// packets, then random well-formed and broken ones and an unthrottled tail -
// with random stalls on both channels, and checks every result against the
// scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

	import vhp_pkg::*;
	import vhp_tb_pkg::*;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned LONG_HOLD   = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	bit          idle_on;
	int unsigned bytes_sent;
	int unsigned packets_sent;
	int unsigned results_seen;
	int unsigned quiet = 0;

	advert_board board = new();

	vrrp_byte_if byte_ch ();
	vrrp_res_if  res_ch ();

	vrrp_header_parser #(
		.POSITION_BITS(POS_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.result_out (res_ch)
	);

	always #5 clk = ~clk;

	function automatic int unsigned addr_span(logic [7:0] cnt, logic v6);
		return cnt * (v6 ? 16 : 4);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic lst, input logic v6);
		int unsigned gap;

		if (idle_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 8);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.byte_value <= b;
		byte_ch.last_byte  <= lst;
		byte_ch.over_ipv6  <= v6;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		board.take_byte(b, lst, v6);
		bytes_sent++;
	endtask

	// fill < 0 gives random bytes; byte 0 and byte 3 always carry ver/type and count
	task automatic send_advert(input logic [3:0] ver, input logic [3:0] typ,
		input logic [7:0] cnt, input logic v6, input int unsigned total, input int fill);
		logic [7:0] b;
		logic       flag;

		for (int unsigned i = 0; i < total; i++) begin
			b    = (fill < 0) ? 8'($urandom) : 8'(fill);
			flag = 1'($urandom);
			if (i == 0) begin
				b    = {ver, typ};
				flag = v6;
			end else if (i == 3) begin
				b = cnt;
			end
			send_byte(b, i == total - 1, flag);
		end
		packets_sent++;
	endtask

	task automatic send_random_advert();
		int unsigned pick;
		int unsigned span;
		int unsigned tail;
		int unsigned total;
		logic [3:0]  ver;
		logic [3:0]  typ;
		logic [7:0]  cnt;
		logic        v6;

		pick = $urandom_range(0, 99);
		v6   = 1'($urandom);
		ver  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(1, 3)) : 4'($urandom);
		typ  = ($urandom_range(0, 3) != 0) ? 4'd1 : 4'($urandom);
		cnt  = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(0, 24));
		if (pick < 10) begin
			total = $urandom_range(1, HDR_LEN - 1);
		end else if (pick < 20) begin
			// cut the address list short
			if (cnt == 0)
				cnt = 8'd1;
			total = $urandom_range(HDR_LEN, HDR_LEN + addr_span(cnt, v6) - 1);
		end else if (pick < 30) begin
			ver = 4'($urandom_range(0, 2));
			do
				tail = $urandom_range(1, 20);
			while (tail == AUTH_LEN);
			total = HDR_LEN + addr_span(cnt, v6) + tail;
		end else begin
			span = HDR_LEN + addr_span(cnt, v6);
			if (ver < VER_AUTH)
				total = span + (($urandom_range(0, 1) != 0) ? AUTH_LEN : 0);
			else
				total = span + $urandom_range(0, 12);
		end
		send_advert(ver, typ, cnt, v6, total, -1);
	endtask

	// Watchdog: give up after a long run of cycles with no transfer on either side
	always @(posedge clk) begin
		if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Result side: check each transfer, stall at random, and hold off once for a long stretch
	initial begin
		int unsigned hold_left;
		bit          pressure_done;
		logic        rdy;
		advert_t     got;

		hold_left     = 0;
		pressure_done = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got.status          = status_t'(res_ch.status);
				got.version         = res_ch.version;
				got.msg_type        = res_ch.msg_type;
				got.router_id       = res_ch.router_id;
				got.priority_res    = res_ch.priority_res;
				got.addr_count      = res_ch.addr_count;
				got.auth_kind       = res_ch.auth_kind;
				got.advert_interval = res_ch.advert_interval;
				got.checksum        = res_ch.checksum;
				got.auth_data       = res_ch.auth_data;
				board.check_result(got);
				results_seen++;
				if (results_seen == 30 && !pressure_done) begin
					hold_left     = LONG_HOLD;
					pressure_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 7);
				rdy       = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			res_ch.ready <= rdy;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		byte_ch.valid      <= 1'b0;
		byte_ch.byte_value <= 8'h00;
		byte_ch.last_byte  <= 1'b0;
		byte_ch.over_ipv6  <= 1'b0;
		idle_on      = 1'b1;
		bytes_sent   = 0;
		packets_sent = 0;
		results_seen = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// too short, at both ends of the range
		send_advert(4'd2, 4'd1, 8'd0, 1'b0, 1, -1);
		send_advert(4'd2, 4'd1, 8'd0, 1'b0, 7, -1);
		// auth part empty, then full
		send_advert(4'd2, 4'd1, 8'd0, 1'b0, HDR_LEN, -1);
		send_advert(4'd2, 4'd1, 8'd1, 1'b0, HDR_LEN + 4 + AUTH_LEN, -1);
		send_advert(4'd1, 4'd1, 8'd1, 1'b1, HDR_LEN + 16 + AUTH_LEN, -1);
		send_advert(4'd0, 4'd0, 8'd0, 1'b0, HDR_LEN + AUTH_LEN, 0);
		send_advert(4'hf, 4'hf, 8'hff, 1'b1, HDR_LEN, 8'hff);
		// version 3: trailing bytes go unchecked
		send_advert(4'd3, 4'd1, 8'd2, 1'b0, HDR_LEN + 8 + 5, -1);
		send_advert(4'd2, 4'd1, 8'd2, 1'b0, HDR_LEN + 8 - 1, -1);
		send_advert(4'd1, 4'd1, 8'd0, 1'b0, HDR_LEN + AUTH_LEN - 1, -1);
		send_advert(4'd2, 4'd1, 8'd0, 1'b1, HDR_LEN + AUTH_LEN + 1, -1);
		send_advert(4'd4, 4'd1, 8'd1, 1'b0, HDR_LEN + 4 + 3, -1);
		send_advert(4'd2, 4'd1, 8'hff, 1'b1, HDR_LEN + AUTH_LEN, -1);
		send_advert(4'd3, 4'd1, 8'd16, 1'b1, HDR_LEN + 256, -1);
		send_advert(4'd2, 4'd1, 8'd1, 1'b1, HDR_LEN + 4, -1);

		while (bytes_sent < 1150 || packets_sent < 40)
			send_random_advert();
		idle_on = 1'b0;
		repeat (20)
			send_random_advert();
		byte_ch.valid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/vhp_pkg.sv
hw/rtl/vrrp_if.sv
hw/rtl/vhp_front.sv
hw/rtl/vhp_queue.sv
hw/rtl/vhp_back.sv
hw/rtl/vrrp_header_parser.sv
tb/sv/vhp_tb_pkg.sv
tb/sv/tb_top.sv
